>>> rtl/cobalt_aqm_mark_drop_assert.svh
// Assertion macros shared by the RTL that checks itself.
`ifndef COBALT_AQM_MARK_DROP_ASSERT_SVH
`define COBALT_AQM_MARK_DROP_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define COBALT_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cobalt assertion failed");

// The consequent holds in the cycle after the antecedent.
`define COBALT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cobalt assertion failed");

`endif

>>> rtl/cobalt_pkg.sv
`default_nettype none
package cobalt_pkg;

    localparam int ROOT_TABLE_DEPTH_DEF = 16;

    localparam logic [31:0] CE_INTERVAL_RST  = 32'd100000000;
    localparam logic [31:0] CE_TARGET_RST    = 32'd5000000;
    localparam logic [31:0] LITE_INTERVAL_RST = 32'd0;
    localparam logic [31:0] LITE_TARGET_RST  = 32'd2500000;
    localparam logic [33:0] BLUE_THRESH_RST  = 34'd400000000;
    localparam logic [31:0] MTU_TIME_RST     = 32'd0;
    localparam logic [31:0] PROB_INC_RST     = 32'h0100_0000;
    localparam logic [31:0] PROB_DEC_RST     = 32'h0010_0000;

    localparam int CFG_INDEX_W = 4;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_CE_INTERVAL   = 4'd0,
        CFG_CE_TARGET     = 4'd1,
        CFG_LITE_INTERVAL = 4'd2,
        CFG_LITE_TARGET   = 4'd3,
        CFG_BLUE_THRESH   = 4'd4,
        CFG_MTU_TIME      = 4'd5,
        CFG_PROB_INC      = 4'd6,
        CFG_PROB_DEC      = 4'd7
    } cfg_index_t;

    // One Newton step for the Q0.32 inverse square root of n.
    function automatic logic [31:0] newton_step(input logic [31:0] n, input logic [31:0] r);
        logic [63:0] r2;
        logic [63:0] v;
        r2 = ({32'b0, r} * {32'b0, r}) >> 32;
        v  = (64'h3_0000_0000 - {32'b0, n} * r2) >> 2;
        v  = (v * {32'b0, r}) >> 31;
        return v[31:0];
    endfunction

    // Table entry n: four Newton steps per count, starting from all ones.
    function automatic logic [31:0] root_entry(input int idx);
        logic [31:0] r;
        r = 32'hFFFF_FFFF;
        for (int n = 1; n <= idx; n++) begin
            r = newton_step(32'(n), r);
            r = newton_step(32'(n), r);
            r = newton_step(32'(n), r);
            r = newton_step(32'(n), r);
        end
        return r;
    endfunction

endpackage
`default_nettype wire

>>> rtl/cobalt_mul32.sv
`default_nettype none
module cobalt_mul32 (
    input  wire logic        clk,
    input  wire logic [31:0] a,
    input  wire logic [31:0] b,
    output logic      [63:0] prod_reg
);

    always_ff @(posedge clk)
    begin
        prod_reg <= {32'b0, a} * {32'b0, b};
    end

endmodule
`default_nettype wire

>>> rtl/cobalt_aqm_mark_drop.sv
// CoDel plus BLUE queue manager, one decision per dequeued word. A word is taken
// when in_ready is high and the block is idle; it then runs on one shared 32x32
// multiplier under a sequencer. Starting a schedule, each inverse-root refresh and
// each schedule step add sequencer states: a refresh takes a Newton step on the
// multiplier when the count lies beyond the table and a table lookup otherwise,
// and the catch-up loops repeat that step, plus a loop test, once per count they
// unwind. A queue-empty word runs its own unwinding steps. The result is held in
// an output register until taken.
`default_nettype none
module cobalt_aqm_mark_drop #(
    parameter int ROOT_TABLE_DEPTH = cobalt_pkg::ROOT_TABLE_DEPTH_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [cobalt_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [33:0]                        cfg_data,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic                               req_type,
    input  wire logic [62:0]                        now_ns,
    input  wire logic [62:0]                        enqueue_ns,
    input  wire logic                               ect_capable,
    input  wire logic                               lite_capable,
    input  wire logic [31:0]                        random_word,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic                                    drop_packet,
    output logic                                    congestion_mark,
    output logic                                    lite_mark
);
    import cobalt_pkg::*;

    localparam int IDX_W = (ROOT_TABLE_DEPTH > 1) ? $clog2(ROOT_TABLE_DEPTH) : 1;

    typedef enum logic [4:0] {
        ST_IDLE, ST_L_EVAL, ST_L_SCHED, ST_L_LOOP, ST_C_EVAL, ST_C_SCHED, ST_C_MARKED,
        ST_C_LOOP, ST_BLUE, ST_TIMEOUT, ST_FINISH, ST_E_BLUE, ST_E_CLOOP, ST_E_LLOOP,
        ST_REF_C, ST_REF_L, ST_NW1, ST_NW2, ST_NW3, ST_NW4, ST_NW5, ST_NW6,
        ST_ADV_MUL, ST_ADV_ADD
    } state_t;

    logic [31:0] root_tab [ROOT_TABLE_DEPTH];

    for (genvar g = 0; g < ROOT_TABLE_DEPTH; g++) begin : g_tab
        assign root_tab[g] = root_entry(g);
    end

    state_t      state_reg, ret_reg;
    logic [31:0] ce_int_reg, ce_tgt_reg, lite_int_reg, lite_tgt_reg;
    logic [33:0] blue_thr_reg;
    logic [31:0] mtu_reg, p_inc_reg, p_dec_reg;
    logic [31:0] c_cnt_reg, c_root_reg, l_cnt_reg, l_root_reg, prob_reg;
    logic [63:0] c_next_reg, l_next_reg, blue_last_reg;
    logic        c_act_reg, l_act_reg;
    logic [63:0] now_reg, soj_reg, sched_reg;
    logic        ect_reg, lcap_reg;
    logic [31:0] rand_reg;
    logic        drop_reg, cmark_reg, lmark_reg, due_reg;
    logic        sel_reg, nsel_reg, adv_now_reg;
    logic [61:0] v_reg;
    logic [31:0] pa_reg;
    logic        out_valid_reg, out_drop_reg, out_ce_reg, out_lite_reg;

    logic [31:0] mul_a, mul_b;
    logic [63:0] prod;
    logic [31:0] n_cnt, n_root, a_int, a_root;
    logic [63:0] a_next, l_diff, c_diff, blue_diff;
    logic        l_over, c_over, drop_final;

    cobalt_mul32 u_mul (
        .clk      (clk),
        .a        (mul_a),
        .b        (mul_b),
        .prod_reg (prod)
    );

    assign n_cnt  = nsel_reg ? l_cnt_reg : c_cnt_reg;
    assign n_root = nsel_reg ? l_root_reg : c_root_reg;
    assign a_int  = sel_reg ? lite_int_reg : ce_int_reg;
    assign a_root = sel_reg ? l_root_reg : c_root_reg;
    assign a_next = adv_now_reg ? now_reg : (sel_reg ? l_next_reg : c_next_reg);

    assign l_diff    = now_reg - l_next_reg;
    assign c_diff    = now_reg - c_next_reg;
    assign blue_diff = now_reg - blue_last_reg;
    assign l_over    = (lite_int_reg != 32'd0) && (soj_reg > {32'b0, lite_tgt_reg})
                       && (soj_reg > {31'b0, mtu_reg, 1'b0});
    assign c_over    = (soj_reg > {32'b0, ce_tgt_reg}) && (soj_reg > {30'b0, mtu_reg, 2'b0});
    assign drop_final = drop_reg || ((prob_reg != 32'd0) && (rand_reg < prob_reg));

    always_comb
    begin
        mul_a = 32'd0;
        mul_b = 32'd0;
        case (state_reg)
            ST_NW1:
            begin
                mul_a = n_root;
                mul_b = n_root;
            end
            ST_NW2:
            begin
                mul_a = n_cnt;
                mul_b = prod[63:32];
            end
            ST_NW4:
            begin
                mul_a = v_reg[31:0];
                mul_b = n_root;
            end
            ST_NW5:
            begin
                mul_a = {2'b0, v_reg[61:32]};
                mul_b = n_root;
            end
            ST_ADV_MUL:
            begin
                mul_a = a_int;
                mul_b = a_root;
            end
            default:
            begin
                mul_a = 32'd0;
                mul_b = 32'd0;
            end
        endcase
    end

    assign cfg_ready       = 1'b1;
    assign in_ready        = (state_reg == ST_IDLE);
    assign out_valid       = out_valid_reg;
    assign drop_packet     = out_drop_reg;
    assign congestion_mark = out_ce_reg;
    assign lite_mark       = out_lite_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ret_reg       <= ST_IDLE;
            ce_int_reg    <= CE_INTERVAL_RST;
            ce_tgt_reg    <= CE_TARGET_RST;
            lite_int_reg  <= LITE_INTERVAL_RST;
            lite_tgt_reg  <= LITE_TARGET_RST;
            blue_thr_reg  <= BLUE_THRESH_RST;
            mtu_reg       <= MTU_TIME_RST;
            p_inc_reg     <= PROB_INC_RST;
            p_dec_reg     <= PROB_DEC_RST;
            c_cnt_reg     <= 32'd0;
            c_root_reg    <= 32'd0;
            l_cnt_reg     <= 32'd0;
            l_root_reg    <= 32'd0;
            prob_reg      <= 32'd0;
            c_next_reg    <= 64'd0;
            l_next_reg    <= 64'd0;
            blue_last_reg <= 64'd0;
            c_act_reg     <= 1'b0;
            l_act_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            out_drop_reg  <= 1'b0;
            out_ce_reg    <= 1'b0;
            out_lite_reg  <= 1'b0;
            now_reg       <= 64'd0;
            soj_reg       <= 64'd0;
            sched_reg     <= 64'd0;
            ect_reg       <= 1'b0;
            lcap_reg      <= 1'b0;
            rand_reg      <= 32'd0;
            drop_reg      <= 1'b0;
            cmark_reg     <= 1'b0;
            lmark_reg     <= 1'b0;
            due_reg       <= 1'b0;
            sel_reg       <= 1'b0;
            nsel_reg      <= 1'b0;
            adv_now_reg   <= 1'b0;
            v_reg         <= 62'd0;
            pa_reg        <= 32'd0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_CE_INTERVAL:   ce_int_reg   <= cfg_data[31:0];
                    CFG_CE_TARGET:     ce_tgt_reg   <= cfg_data[31:0];
                    CFG_LITE_INTERVAL: lite_int_reg <= cfg_data[31:0];
                    CFG_LITE_TARGET:   lite_tgt_reg <= cfg_data[31:0];
                    CFG_BLUE_THRESH:   blue_thr_reg <= cfg_data;
                    CFG_MTU_TIME:      mtu_reg      <= cfg_data[31:0];
                    CFG_PROB_INC:      p_inc_reg    <= cfg_data[31:0];
                    CFG_PROB_DEC:      p_dec_reg    <= cfg_data[31:0];
                    default:           ;
                endcase
            end

            if (out_valid_reg && out_ready && (state_reg != ST_FINISH))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg) inside
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        now_reg   <= {1'b0, now_ns};
                        soj_reg   <= {1'b0, now_ns} - {1'b0, enqueue_ns};
                        ect_reg   <= ect_capable;
                        lcap_reg  <= lite_capable;
                        rand_reg  <= random_word;
                        drop_reg  <= 1'b0;
                        cmark_reg <= 1'b0;
                        lmark_reg <= 1'b0;
                        state_reg <= req_type ? ST_E_BLUE : ST_L_EVAL;
                    end
                end
                ST_L_EVAL:
                begin
                    due_reg <= (l_cnt_reg != 32'd0) && !l_diff[63];
                    if (l_over)
                    begin
                        if (l_cnt_reg == 32'd0)
                        begin
                            l_cnt_reg <= 32'd1;
                        end
                        if (!l_act_reg)
                        begin
                            l_act_reg   <= 1'b1;
                            sel_reg     <= 1'b1;
                            adv_now_reg <= 1'b1;
                            ret_reg     <= ST_L_SCHED;
                            state_reg   <= ST_ADV_MUL;
                        end
                        else
                        begin
                            state_reg <= ST_L_SCHED;
                        end
                    end
                    else
                    begin
                        l_act_reg <= 1'b0;
                        state_reg <= ST_L_SCHED;
                    end
                end
                ST_L_SCHED:
                begin
                    sel_reg     <= 1'b1;
                    adv_now_reg <= 1'b0;
                    if (due_reg && l_act_reg)
                    begin
                        if (lcap_reg)
                        begin
                            lmark_reg <= 1'b1;
                            if (l_cnt_reg != 32'hFFFF_FFFF)
                            begin
                                l_cnt_reg <= l_cnt_reg + 32'd1;
                            end
                            ret_reg   <= ST_C_EVAL;
                            state_reg <= ST_REF_C;
                        end
                        else
                        begin
                            state_reg <= ST_C_EVAL;
                        end
                    end
                    else if (due_reg)
                    begin
                        l_cnt_reg <= l_cnt_reg - 32'd1;
                        ret_reg   <= ST_L_LOOP;
                        state_reg <= ST_REF_C;
                    end
                    else
                    begin
                        state_reg <= ST_C_EVAL;
                    end
                end
                ST_L_LOOP, ST_E_LLOOP:
                begin
                    sel_reg     <= 1'b1;
                    adv_now_reg <= 1'b0;
                    if ((l_cnt_reg != 32'd0) && !l_diff[63])
                    begin
                        l_cnt_reg <= l_cnt_reg - 32'd1;
                        ret_reg   <= state_reg;
                        state_reg <= ST_REF_C;
                    end
                    else
                    begin
                        state_reg <= (state_reg == ST_L_LOOP) ? ST_C_EVAL : ST_FINISH;
                    end
                end
                ST_C_EVAL:
                begin
                    due_reg   <= (c_cnt_reg != 32'd0) && !c_diff[63];
                    sched_reg <= c_diff;
                    if (c_over)
                    begin
                        if (c_cnt_reg == 32'd0)
                        begin
                            c_cnt_reg <= 32'd1;
                        end
                        if (!c_act_reg)
                        begin
                            c_act_reg   <= 1'b1;
                            sel_reg     <= 1'b0;
                            adv_now_reg <= 1'b1;
                            ret_reg     <= ST_C_SCHED;
                            state_reg   <= ST_ADV_MUL;
                        end
                        else
                        begin
                            state_reg <= ST_C_SCHED;
                        end
                    end
                    else
                    begin
                        c_act_reg <= 1'b0;
                        state_reg <= ST_C_SCHED;
                    end
                end
                ST_C_SCHED:
                begin
                    sel_reg     <= 1'b0;
                    adv_now_reg <= 1'b0;
                    if (due_reg && c_act_reg)
                    begin
                        cmark_reg <= ect_reg;
                        drop_reg  <= !ect_reg;
                        if (c_cnt_reg != 32'hFFFF_FFFF)
                        begin
                            c_cnt_reg <= c_cnt_reg + 32'd1;
                        end
                        ret_reg   <= ST_C_MARKED;
                        state_reg <= ST_REF_C;
                    end
                    else if (due_reg)
                    begin
                        c_cnt_reg <= c_cnt_reg - 32'd1;
                        ret_reg   <= ST_C_LOOP;
                        state_reg <= ST_REF_C;
                    end
                    else
                    begin
                        state_reg <= ST_BLUE;
                    end
                end
                ST_C_MARKED:
                begin
                    sched_reg <= c_diff;
                    state_reg <= ST_BLUE;
                end
                ST_C_LOOP:
                begin
                    sched_reg   <= c_diff;
                    sel_reg     <= 1'b0;
                    adv_now_reg <= 1'b0;
                    if ((c_cnt_reg != 32'd0) && !c_diff[63])
                    begin
                        c_cnt_reg <= c_cnt_reg - 32'd1;
                        ret_reg   <= ST_C_LOOP;
                        state_reg <= ST_REF_C;
                    end
                    else
                    begin
                        state_reg <= ST_BLUE;
                    end
                end
                ST_BLUE:
                begin
                    if (soj_reg > {30'b0, blue_thr_reg})
                    begin
                        if (blue_diff > {32'b0, ce_tgt_reg})
                        begin
                            prob_reg      <= ((prob_reg + p_inc_reg) < p_inc_reg) ?
                                             32'hFFFF_FFFF : prob_reg + p_inc_reg;
                            blue_last_reg <= now_reg;
                        end
                        c_act_reg  <= 1'b1;
                        c_next_reg <= now_reg;
                        if (c_cnt_reg == 32'd0)
                        begin
                            c_cnt_reg <= 32'd1;
                        end
                        if (lite_int_reg != 32'd0)
                        begin
                            l_act_reg  <= 1'b1;
                            l_next_reg <= now_reg;
                            if (l_cnt_reg == 32'd0)
                            begin
                                l_cnt_reg <= 32'd1;
                            end
                        end
                    end
                    state_reg <= ST_TIMEOUT;
                end
                ST_TIMEOUT:
                begin
                    drop_reg <= drop_final;
                    if (c_cnt_reg == 32'd0)
                    begin
                        c_next_reg <= now_reg + {32'b0, ce_int_reg};
                    end
                    else if ((sched_reg != 64'd0) && !sched_reg[63] && !drop_final)
                    begin
                        c_next_reg <= now_reg;
                    end
                    state_reg <= ST_FINISH;
                end
                ST_FINISH:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_drop_reg  <= drop_reg;
                        out_ce_reg    <= cmark_reg;
                        out_lite_reg  <= lmark_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                ST_E_BLUE:
                begin
                    if ((prob_reg != 32'd0) && (blue_diff > {32'b0, ce_tgt_reg}))
                    begin
                        prob_reg      <= (prob_reg < p_dec_reg) ? 32'd0 : prob_reg - p_dec_reg;
                        blue_last_reg <= now_reg;
                    end
                    c_act_reg <= 1'b0;
                    l_act_reg <= 1'b0;
                    state_reg <= ST_E_CLOOP;
                end
                ST_E_CLOOP:
                begin
                    sel_reg     <= 1'b0;
                    adv_now_reg <= 1'b0;
                    if ((c_cnt_reg != 32'd0) && !c_diff[63])
                    begin
                        c_cnt_reg <= c_cnt_reg - 32'd1;
                        ret_reg   <= ST_E_CLOOP;
                        state_reg <= ST_REF_C;
                    end
                    else
                    begin
                        state_reg <= ST_E_LLOOP;
                    end
                end
                ST_REF_C:
                begin
                    nsel_reg <= 1'b0;
                    if (c_cnt_reg < 32'(ROOT_TABLE_DEPTH))
                    begin
                        c_root_reg <= root_tab[c_cnt_reg[IDX_W-1:0]];
                        state_reg  <= ST_REF_L;
                    end
                    else
                    begin
                        state_reg <= ST_NW1;
                    end
                end
                ST_REF_L:
                begin
                    nsel_reg <= 1'b1;
                    if (l_cnt_reg < 32'(ROOT_TABLE_DEPTH))
                    begin
                        l_root_reg <= root_tab[l_cnt_reg[IDX_W-1:0]];
                        state_reg  <= ST_ADV_MUL;
                    end
                    else
                    begin
                        state_reg <= ST_NW1;
                    end
                end
                ST_NW1:
                begin
                    state_reg <= ST_NW2;
                end
                ST_NW2:
                begin
                    state_reg <= ST_NW3;
                end
                ST_NW3:
                begin
                    v_reg     <= 62'((64'h3_0000_0000 - prod) >> 2);
                    state_reg <= ST_NW4;
                end
                ST_NW4:
                begin
                    state_reg <= ST_NW5;
                end
                ST_NW5:
                begin
                    pa_reg    <= prod[62:31];
                    state_reg <= ST_NW6;
                end
                ST_NW6:
                begin
                    if (nsel_reg)
                    begin
                        l_root_reg <= {pa_reg[31:1] + prod[30:0], pa_reg[0]};
                        state_reg  <= ST_ADV_MUL;
                    end
                    else
                    begin
                        c_root_reg <= {pa_reg[31:1] + prod[30:0], pa_reg[0]};
                        state_reg  <= ST_REF_L;
                    end
                end
                ST_ADV_MUL:
                begin
                    state_reg <= ST_ADV_ADD;
                end
                ST_ADV_ADD:
                begin
                    if (sel_reg)
                    begin
                        l_next_reg <= a_next + {32'b0, prod[63:32]};
                    end
                    else
                    begin
                        c_next_reg <= a_next + {32'b0, prod[63:32]};
                    end
                    state_reg <= ret_reg;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

`include "cobalt_aqm_mark_drop_assert.svh"

    `COBALT_ASSERT_NEXT(a_busy_after_take, in_valid && in_ready, !in_ready)
    `COBALT_ASSERT_SAME(a_ce_active_count, c_act_reg, c_cnt_reg != 32'd0)
    `COBALT_ASSERT_SAME(a_lite_active_count, l_act_reg, l_cnt_reg != 32'd0)
    `COBALT_ASSERT_SAME(a_result_from_finish, $rose(out_valid_reg), $past(state_reg == ST_FINISH))

endmodule
`default_nettype wire
